### src/rv64_subset_instruction_execute_assert.svh
// assertion macros for the rv64 subset execute block
`ifndef RV64_SUBSET_INSTRUCTION_EXECUTE_ASSERT_SVH
`define RV64_SUBSET_INSTRUCTION_EXECUTE_ASSERT_SVH

// implication checked on every edge outside reset
`define RVX_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rvx check failed");

// implication checked in the cycle after the antecedent
`define RVX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rvx check failed");

`endif

### src/rvx_pkg.sv
`default_nettype none
package rvx_pkg;
    localparam int unsigned MEMORY_ADDRESS_BITS_DEFAULT = 16;
    localparam logic [63:0] START_RESET = 64'h0000_0000_8000_0000;
    localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
    localparam logic [4:0]  HALT_REG    = 5'd10;

    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_REG32  = 7'h3B;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_IMM32  = 7'h1B;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6F;

    localparam logic [6:0] F7_ZERO = 7'h00;
    localparam logic [6:0] F7_SUB  = 7'h20;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SH   = 3'd1;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LD   = 3'd3;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_SRA  = 3'd5;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;

    localparam logic [3:0] BYTES_NONE = 4'd0;
    localparam logic [3:0] BYTES_HALF = 4'd2;
    localparam logic [3:0] BYTES_DBL  = 4'd8;

    typedef enum logic [1:0] {
        ST_EXECUTED = 2'd0,
        ST_EBREAK   = 2'd1,
        ST_INVALID  = 2'd2,
        ST_IGNORED  = 2'd3
    } status_t;
endpackage
`default_nettype wire

### src/rv64_subset_instruction_execute.sv
`default_nettype none
// RV64I subset execute block: each item is one 32-bit instruction that is run against the
// block's own pc, 32 x 64-bit register file (x0 reads zero) and a byte-addressed
// little-endian data memory of 2**MEMORY_ADDRESS_BITS bytes, split into eight byte banks
// so any 8-byte access, aligned or not, wrapping or not, costs one bank read or write.
// After reset the block sweeps the banks to zero row by row (instr_ready stays low;
// configuration writes during the pass are dropped) and then loads pc from start_address.
// An item passes through a register file read, then execute and writeback; a load adds a
// bank read state, as the bank read needs the address formed from the register read.
// Results sit in an output register, so the next item is accepted while a result waits.
// After ebreak or an invalid instruction every further item returns status ignored.
module rv64_subset_instruction_execute #(
    parameter int unsigned MEMORY_ADDRESS_BITS = rvx_pkg::MEMORY_ADDRESS_BITS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_enable,
    input  wire logic [63:0] cfg_write_data,
    input  wire logic        instr_valid,
    output logic             instr_ready,
    input  wire logic [31:0] instruction,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [63:0]      executed_pc,
    output logic [63:0]      next_pc,
    output logic [1:0]       status,
    output logic             reg_write_enable,
    output logic [4:0]       reg_index,
    output logic [63:0]      reg_value,
    output logic [3:0]       store_bytes,
    output logic [63:0]      store_address,
    output logic [63:0]      store_data,
    output logic [63:0]      halt_code
);
    import rvx_pkg::*;

    localparam int unsigned ROW_BITS = MEMORY_ADDRESS_BITS - 3;
    localparam int unsigned ROWS     = 1 << ROW_BITS;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_LOAD} state_t;

    // control and architectural state
    state_t              state_reg;
    logic [ROW_BITS-1:0] clr_cnt_reg;
    logic [63:0]         start_address_reg;
    logic [63:0]         pc_reg;
    logic                halted_reg;
    logic [31:0]         instr_reg;
    logic [31:0]         rf_valid_reg;

    // register file, two copies give two read ports
    logic [63:0] rf_a_mem [32];
    logic [63:0] rf_b_mem [32];
    logic [63:0] rf_a_q, rf_b_q;
    logic        rf_a_vld_q, rf_b_vld_q;

    // data memory, eight byte banks, bank k holds the bytes with address[2:0] == k
    logic [7:0] mem [8][ROWS];
    logic [7:0] bank_q [8];
    logic [2:0] load_lo_reg;
    logic       load_word_reg;

    // output register
    logic        out_valid_reg;
    logic [63:0] out_epc_reg, out_npc_reg, out_val_reg, out_saddr_reg, out_sdata_reg;
    logic [63:0] out_hcode_reg;
    status_t     out_status_reg;
    logic        out_we_reg;
    logic [4:0]  out_idx_reg;
    logic [3:0]  out_sbytes_reg;

    // read addresses: from the incoming item while idle, else from the held item
    logic [31:0] rd_word;
    logic [4:0]  ra, rb;
    assign rd_word = (state_reg == S_IDLE) ? instruction : instr_reg;
    assign ra = (rd_word == EBREAK_WORD) ? HALT_REG : rd_word[19:15];
    assign rb = rd_word[24:20];

    logic accept, out_free;
    assign instr_ready = (state_reg == S_IDLE);
    assign accept      = instr_valid && instr_ready;
    assign out_free    = !out_valid_reg || result_ready;

    // decode of the held item
    logic [6:0]  op, f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [63:0] a, b, imm_i, imm_s, imm_b, imm_u, imm_j, pc4;
    assign op = instr_reg[6:0];
    assign f3 = instr_reg[14:12];
    assign f7 = instr_reg[31:25];
    assign rd = instr_reg[11:7];
    assign a  = rf_a_vld_q ? rf_a_q : 64'd0;
    assign b  = rf_b_vld_q ? rf_b_q : 64'd0;
    assign imm_i = {{52{instr_reg[31]}}, instr_reg[31:20]};
    assign imm_s = {{52{instr_reg[31]}}, instr_reg[31:25], instr_reg[11:7]};
    assign imm_b = {{51{instr_reg[31]}}, instr_reg[31], instr_reg[7], instr_reg[30:25],
                    instr_reg[11:8], 1'b0};
    assign imm_u = {{32{instr_reg[31]}}, instr_reg[31:12], 12'd0};
    assign imm_j = {{43{instr_reg[31]}}, instr_reg[31], instr_reg[19:12], instr_reg[20],
                    instr_reg[30:21], 1'b0};
    assign pc4 = pc_reg + 64'd4;

    logic [63:0] ea_i, ea_s, sum_ab, sum_w, sum_iw;
    assign ea_i   = a + imm_i;
    assign ea_s   = a + imm_s;
    assign sum_ab = a + b;
    assign sum_w  = {{32{sum_ab[31]}}, sum_ab[31:0]};
    assign sum_iw = {{32{ea_i[31]}}, ea_i[31:0]};

    // execute result
    status_t     ex_status;
    logic        ex_wr, ex_load;
    logic [63:0] ex_val, ex_npc, ex_saddr, ex_sdata, ex_hcode;
    logic [3:0]  ex_sbytes;

    always_comb
    begin
        ex_status = ST_EXECUTED;
        ex_wr     = 1'b0;
        ex_load   = 1'b0;
        ex_val    = 64'd0;
        ex_npc    = pc4;
        ex_saddr  = 64'd0;
        ex_sdata  = 64'd0;
        ex_hcode  = 64'd0;
        ex_sbytes = BYTES_NONE;
        if (instr_reg == EBREAK_WORD) begin
            ex_status = ST_EBREAK;
            ex_hcode  = a;
        end else begin
            unique case (op)
                OP_AUIPC:
                begin
                    ex_wr = 1'b1; ex_val = pc_reg + imm_u;
                end
                OP_REG:
                begin
                    if (f3 == F3_ADD && f7 == F7_ZERO) begin
                        ex_wr = 1'b1; ex_val = sum_ab;
                    end else if (f3 == F3_ADD && f7 == F7_SUB) begin
                        ex_wr = 1'b1; ex_val = a - b;
                    end else begin
                        ex_status = ST_INVALID;
                    end
                end
                OP_REG32:
                begin
                    if (f3 == F3_ADD && f7 == F7_ZERO) begin
                        ex_wr = 1'b1; ex_val = sum_w;
                    end else begin
                        ex_status = ST_INVALID;
                    end
                end
                OP_LOAD:
                begin
                    if (f3 == F3_LD || f3 == F3_LW) begin
                        ex_wr = 1'b1; ex_load = 1'b1;
                    end else begin
                        ex_status = ST_INVALID;
                    end
                end
                OP_IMM:
                begin
                    case (f3)
                        F3_ADD:  begin ex_wr = 1'b1; ex_val = ea_i; end
                        F3_SLTU: begin ex_wr = 1'b1; ex_val = {63'd0, a < imm_i}; end
                        F3_SRA:
                        begin
                            ex_wr  = 1'b1;
                            ex_val = $unsigned($signed(a) >>> instr_reg[25:20]);
                        end
                        default: ex_status = ST_INVALID;
                    endcase
                end
                OP_IMM32:
                begin
                    if (f3 == F3_ADD) begin
                        ex_wr = 1'b1; ex_val = sum_iw;
                    end else begin
                        ex_status = ST_INVALID;
                    end
                end
                OP_JALR:
                begin
                    if (f3 == F3_ADD) begin
                        ex_wr = 1'b1; ex_val = pc4; ex_npc = {ea_i[63:1], 1'b0};
                    end else begin
                        ex_status = ST_INVALID;
                    end
                end
                OP_STORE:
                begin
                    if (f3 == F3_LD) begin
                        ex_sbytes = BYTES_DBL; ex_saddr = ea_s; ex_sdata = b;
                    end else if (f3 == F3_SH) begin
                        ex_sbytes = BYTES_HALF; ex_saddr = ea_s; ex_sdata = {48'd0, b[15:0]};
                    end else begin
                        ex_status = ST_INVALID;
                    end
                end
                OP_BRANCH:
                begin
                    if (f3 == F3_BEQ) begin
                        if (a == b) ex_npc = pc_reg + imm_b;
                    end else if (f3 == F3_BNE) begin
                        if (a != b) ex_npc = pc_reg + imm_b;
                    end else begin
                        ex_status = ST_INVALID;
                    end
                end
                OP_JAL:
                begin
                    ex_wr = 1'b1; ex_val = pc4; ex_npc = pc_reg + imm_j;
                end
                default: ex_status = ST_INVALID;
            endcase
        end
    end

    // bank addressing for the access at the item's effective address
    logic [63:0]         mem_ea;
    logic [2:0]          ea_lo;
    logic [ROW_BITS-1:0] ea_row;
    logic [ROW_BITS-1:0] bank_row [8];
    logic [2:0]          bank_off [8];
    logic                bank_we  [8];
    logic [7:0]          bank_wd  [8];
    logic                do_store;

    assign mem_ea   = (op == OP_LOAD) ? ea_i : ea_s;
    assign ea_lo    = mem_ea[2:0];
    assign ea_row   = mem_ea[MEMORY_ADDRESS_BITS-1:3];
    assign do_store = (state_reg == S_EXEC) && !halted_reg && out_free
                      && (ex_sbytes != BYTES_NONE);

    always_comb
    begin
        for (int k = 0; k < 8; k++) begin
            bank_off[k] = 3'(k) - ea_lo;
            bank_row[k] = ea_row + ROW_BITS'(3'(k) < ea_lo);
            bank_we[k]  = do_store && ({1'b0, bank_off[k]} < ex_sbytes);
            bank_wd[k]  = ex_sdata[{bank_off[k], 3'b000} +: 8];
        end
    end

    // assembled load data
    logic [63:0] load_raw, load_val;
    always_comb
    begin
        for (int j = 0; j < 8; j++) begin
            load_raw[8*j +: 8] = bank_q[3'(j) + load_lo_reg];
        end
    end
    assign load_val = load_word_reg ? {{32{load_raw[31]}}, load_raw[31:0]} : load_raw;

    // banks: sweep to zero after reset, then read and write at the item's rows
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 8; k++) begin
            if (state_reg == S_CLEAR) begin
                mem[k][clr_cnt_reg] <= 8'd0;
            end else if (bank_we[k]) begin
                mem[k][bank_row[k]] <= bank_wd[k];
            end
            bank_q[k] <= mem[k][bank_row[k]];
        end
    end

    // register file read and write back
    logic        wb_en;
    logic [63:0] wb_val;
    logic        finish;
    assign finish = ((state_reg == S_EXEC && (halted_reg || !ex_load))
                     || state_reg == S_LOAD) && out_free;
    assign wb_val = (state_reg == S_LOAD) ? load_val : ex_val;
    assign wb_en  = finish && !halted_reg && ex_wr && (rd != 5'd0);

    always_ff @(posedge clk)
    begin
        if (wb_en) begin
            rf_a_mem[rd] <= wb_val;
            rf_b_mem[rd] <= wb_val;
        end
        rf_a_q <= rf_a_mem[ra];
        rf_b_q <= rf_b_mem[rb];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg         <= S_CLEAR;
            clr_cnt_reg       <= '0;
            start_address_reg <= START_RESET;
            pc_reg            <= START_RESET;
            halted_reg        <= 1'b0;
            rf_valid_reg      <= '0;
            rf_a_vld_q        <= 1'b0;
            rf_b_vld_q        <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            // a write only counts for the next reset, which restores the default anyway
            if (cfg_write_enable && state_reg != S_CLEAR) start_address_reg <= cfg_write_data;
            rf_a_vld_q <= rf_valid_reg[ra];
            rf_b_vld_q <= rf_valid_reg[rb];
            if (wb_en) rf_valid_reg[rd] <= 1'b1;
            if (finish) out_valid_reg <= 1'b1;
            else if (result_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == ROW_BITS'(ROWS - 1)) begin
                        state_reg <= S_IDLE;
                        pc_reg    <= start_address_reg;
                    end
                end
                S_IDLE:
                begin
                    if (accept) state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (!halted_reg && ex_load) begin
                        state_reg <= S_LOAD;
                    end else if (out_free) begin
                        state_reg <= S_IDLE;
                        if (!halted_reg) begin
                            pc_reg <= ex_npc;
                            if (ex_status != ST_EXECUTED) halted_reg <= 1'b1;
                        end
                    end
                end
                S_LOAD:
                begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                        pc_reg    <= pc4;
                    end
                end
                default: state_reg <= S_CLEAR;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept) instr_reg <= instruction;
        if (state_reg == S_EXEC) begin
            load_lo_reg   <= ea_lo;
            load_word_reg <= (f3 == F3_LW);
        end
        if (finish) begin
            out_epc_reg <= pc_reg;
            if (halted_reg) begin
                out_npc_reg    <= pc_reg;
                out_status_reg <= ST_IGNORED;
                out_we_reg     <= 1'b0;
                out_idx_reg    <= 5'd0;
                out_val_reg    <= 64'd0;
                out_sbytes_reg <= BYTES_NONE;
                out_saddr_reg  <= 64'd0;
                out_sdata_reg  <= 64'd0;
                out_hcode_reg  <= 64'd0;
            end else begin
                out_npc_reg    <= (state_reg == S_LOAD) ? pc4 : ex_npc;
                out_status_reg <= ex_status;
                out_we_reg     <= wb_en;
                out_idx_reg    <= wb_en ? rd : 5'd0;
                out_val_reg    <= wb_en ? wb_val : 64'd0;
                out_sbytes_reg <= ex_sbytes;
                out_saddr_reg  <= ex_saddr;
                out_sdata_reg  <= ex_sdata;
                out_hcode_reg  <= ex_hcode;
            end
        end
    end

    assign result_valid     = out_valid_reg;
    assign executed_pc      = out_epc_reg;
    assign next_pc          = out_npc_reg;
    assign status           = out_status_reg;
    assign reg_write_enable = out_we_reg;
    assign reg_index        = out_idx_reg;
    assign reg_value        = out_val_reg;
    assign store_bytes      = out_sbytes_reg;
    assign store_address    = out_saddr_reg;
    assign store_data       = out_sdata_reg;
    assign halt_code        = out_hcode_reg;

`include "rv64_subset_instruction_execute_assert.svh"

    `RVX_ASSERT_NEXT(a_accept_exec, accept, state_reg == S_EXEC)
    `RVX_ASSERT_IMP(a_no_write_halted, halted_reg, !wb_en && !do_store)
    `RVX_ASSERT_IMP(a_store_no_wb, result_valid && store_bytes != BYTES_NONE, !reg_write_enable)
    `RVX_ASSERT_NEXT(a_halt_sticks, halted_reg, halted_reg)

endmodule
`default_nettype wire
